// ----- hdl/ffdc_pkg.sv -----
// shared types and constants of the fixed frame deframer and checker
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package ffdc_pkg;

  // frame geometry
  localparam int unsigned FRAME_BYTES = 64;
  localparam int unsigned INFO_BYTES  = 44;
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);

  localparam logic [POS_W-1:0] POS_FIRST_FLAG = POS_W'(0);
  localparam logic [POS_W-1:0] POS_DEST_LAST  = POS_W'(6);
  localparam logic [POS_W-1:0] POS_DEST_SSID  = POS_W'(7);
  localparam logic [POS_W-1:0] POS_SRC_LAST   = POS_W'(13);
  localparam logic [POS_W-1:0] POS_SRC_SSID   = POS_W'(14);
  localparam logic [POS_W-1:0] POS_CONTROL    = POS_W'(15);
  localparam logic [POS_W-1:0] POS_PID        = POS_W'(16);
  localparam logic [POS_W-1:0] POS_INFO_FIRST = POS_W'(17);
  localparam logic [POS_W-1:0] POS_HSUM       = POS_W'(17 + INFO_BYTES);
  localparam logic [POS_W-1:0] POS_ISUM       = POS_W'(18 + INFO_BYTES);
  localparam logic [POS_W-1:0] POS_LAST       = POS_W'(FRAME_BYTES - 1);

  // byte codes
  localparam logic [7:0] FLAG_BYTE = 8'h7e;
  localparam logic [7:0] PID_NONE  = 8'hf0;
  localparam logic [7:0] SSID_RES  = 8'h60;
  localparam logic [7:0] SSID_CBIT = 8'h80;
  localparam logic [2:0] SEQ_MASK  = 3'h7;

  localparam logic [47:0] STATION_RESET = 48'h8C8A929886A0;

  // result kinds
  localparam logic KIND_INFO   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // frame status codes
  localparam logic [3:0] ST_INFO       = 4'd0;
  localparam logic [3:0] ST_SUPERVISOR = 4'd1;
  localparam logic [3:0] ST_START_FLAG = 4'd2;
  localparam logic [3:0] ST_END_FLAG   = 4'd3;
  localparam logic [3:0] ST_HDR_SUM    = 4'd4;
  localparam logic [3:0] ST_ADDRESS    = 4'd5;
  localparam logic [3:0] ST_DEST_SSID  = 4'd6;
  localparam logic [3:0] ST_SRC_SSID   = 4'd7;
  localparam logic [3:0] ST_PAIRING    = 4'd8;
  localparam logic [3:0] ST_PID        = 4'd9;
  localparam logic [3:0] ST_INFO_SUM   = 4'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  info_byte;
    logic [5:0]  info_index;
    logic [3:0]  frame_status;
    logic [47:0] sender_address;
    logic        frame_is_response;
    logic [2:0]  send_sequence;
    logic [2:0]  receive_sequence;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hdl/fixed_frame_deframer_checker.sv -----
// top level of the fixed 64-byte frame deframer and checker
// depends on ffdc_pkg, ffdc_frame_track and ffdc_out_reg
`default_nettype none

// Takes one byte of a fixed 64-byte frame per item and checks it in one pass.
// Byte 0 and byte 63 must be the 0x7e flag; bytes 1-16 are the header
// (destination, SSIDs, source, control, PID), bytes 17-60 the 44 info bytes,
// 61 and 62 the two's-complement checksums of header and info. Every info
// byte comes out as an info item as it passes (none for a supervisory frame),
// and byte 63 produces one status item with the source address, command or
// response, N(S) and N(R). in_item.frame_start marks byte 0; without it the
// position simply counts on and wraps after 63. One item per cycle while the
// result register is free: each byte sits in an input register, runs through
// the combinational checker logic and any item it yields lands in the result
// register, which drives out_valid. Backpressure from out_ready holds the
// input register. station_address must be written through cfg_ only while
// the block is idle (not enforced by the block); it resets to 0x8C8A929886A0.

module fixed_frame_deframer_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,

  // byte items in
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ffdc_pkg::in_item_t in_item,

  // info and status items out
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ffdc_pkg::out_item_t     out_item,

  // station address register write
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [47:0]        cfg_data
);

  // input register stage
  logic               s0_valid_r, s0_valid_nxt;
  ffdc_pkg::in_item_t s0_item_r;

  // own station address
  logic [47:0] station_r;

  // checker results
  logic                res_valid;
  ffdc_pkg::out_item_t res_item;
  logic                out_free;
  logic                step;
  logic                in_fire;

  // the held byte is processed once the result slot can take its result
  assign step         = s0_valid_r && out_free;
  assign in_ready     = !s0_valid_r || out_free;
  assign in_fire      = in_valid && in_ready;
  assign s0_valid_nxt = in_fire ? 1'b1 : (s0_valid_r && !step);
  assign cfg_ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      station_r  <= ffdc_pkg::STATION_RESET;
    end else begin
      s0_valid_r <= s0_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        station_r <= cfg_data;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_item_r <= in_item;
    end
  end

  ffdc_frame_track u_track (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .item            (s0_item_r),
    .station_address (station_r),
    .res_valid       (res_valid),
    .res_item        (res_item)
  );

  ffdc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_valid),
    .load_item (res_item),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ----- hdl/ffdc_frame_track.sv -----
// per-frame state and single pass check logic of the deframer
// depends on ffdc_pkg; feeds ffdc_out_reg
`default_nettype none

module ffdc_frame_track (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire ffdc_pkg::in_item_t item,
  input  wire logic [47:0]       station_address,
  output logic                   res_valid,
  output ffdc_pkg::out_item_t    res_item
);

  logic [ffdc_pkg::POS_W-1:0] pos_r, pos_nxt, pos;
  logic [7:0]  header_sum_r, header_sum_nxt;
  logic [7:0]  info_sum_r, info_sum_nxt;
  logic        start_ok_r, start_ok_nxt;
  logic        addr_miss_r, addr_miss_nxt;
  logic [7:0]  dest_ssid_r, dest_ssid_nxt;
  logic [47:0] source_r, source_nxt;
  logic [7:0]  src_ssid_r, src_ssid_nxt;
  logic [7:0]  control_r, control_nxt;
  logic [7:0]  pid_r, pid_nxt;
  logic        hsum_bad_r, hsum_bad_nxt;
  logic        isum_bad_r, isum_bad_nxt;

  logic [7:0]  b;
  logic [7:0]  own_byte;
  logic [3:0]  st;
  logic        dc, sc, sup;

  assign b   = item.data_byte;
  assign pos = item.frame_start ? ffdc_pkg::POS_FIRST_FLAG : pos_r;
  assign dc  = (dest_ssid_r & ffdc_pkg::SSID_CBIT) != 8'd0;
  assign sc  = (src_ssid_r & ffdc_pkg::SSID_CBIT) != 8'd0;
  assign sup = control_r[0];

  // own address byte for positions 1..6, first byte in the top bits
  always_comb begin
    case (pos)
      6'd1:    own_byte = station_address[47:40];
      6'd2:    own_byte = station_address[39:32];
      6'd3:    own_byte = station_address[31:24];
      6'd4:    own_byte = station_address[23:16];
      6'd5:    own_byte = station_address[15:8];
      default: own_byte = station_address[7:0];
    endcase
  end

  // status priority at the closing flag
  always_comb begin
    if (!start_ok_r)
      st = ffdc_pkg::ST_START_FLAG;
    else if (b != ffdc_pkg::FLAG_BYTE)
      st = ffdc_pkg::ST_END_FLAG;
    else if (hsum_bad_r)
      st = ffdc_pkg::ST_HDR_SUM;
    else if (addr_miss_r)
      st = ffdc_pkg::ST_ADDRESS;
    else if ((dest_ssid_r & ffdc_pkg::SSID_RES) != ffdc_pkg::SSID_RES || dest_ssid_r[0])
      st = ffdc_pkg::ST_DEST_SSID;
    else if ((src_ssid_r & ffdc_pkg::SSID_RES) != ffdc_pkg::SSID_RES || !src_ssid_r[0])
      st = ffdc_pkg::ST_SRC_SSID;
    else if (dc == sc)
      st = ffdc_pkg::ST_PAIRING;
    else if (sup)
      st = ffdc_pkg::ST_SUPERVISOR;
    else if (pid_r != ffdc_pkg::PID_NONE)
      st = ffdc_pkg::ST_PID;
    else if (isum_bad_r)
      st = ffdc_pkg::ST_INFO_SUM;
    else
      st = ffdc_pkg::ST_INFO;
  end

  always_comb begin
    pos_nxt        = pos + 6'd1;
    header_sum_nxt = header_sum_r;
    info_sum_nxt   = info_sum_r;
    start_ok_nxt   = start_ok_r;
    addr_miss_nxt  = addr_miss_r;
    dest_ssid_nxt  = dest_ssid_r;
    source_nxt     = source_r;
    src_ssid_nxt   = src_ssid_r;
    control_nxt    = control_r;
    pid_nxt        = pid_r;
    hsum_bad_nxt   = hsum_bad_r;
    isum_bad_nxt   = isum_bad_r;
    res_valid      = 1'b0;
    res_item       = '0;

    if (pos == ffdc_pkg::POS_FIRST_FLAG) begin
      header_sum_nxt = 8'd0;
      info_sum_nxt   = 8'd0;
      start_ok_nxt   = (b == ffdc_pkg::FLAG_BYTE);
      addr_miss_nxt  = 1'b0;
      dest_ssid_nxt  = 8'd0;
      source_nxt     = 48'd0;
      src_ssid_nxt   = 8'd0;
      control_nxt    = 8'd0;
      pid_nxt        = 8'd0;
      hsum_bad_nxt   = 1'b0;
      isum_bad_nxt   = 1'b0;
    end else if (pos <= ffdc_pkg::POS_PID) begin
      header_sum_nxt = header_sum_r + b;
      if (pos <= ffdc_pkg::POS_DEST_LAST) begin
        if (own_byte != b)
          addr_miss_nxt = 1'b1;
      end else if (pos == ffdc_pkg::POS_DEST_SSID) begin
        dest_ssid_nxt = b;
      end else if (pos <= ffdc_pkg::POS_SRC_LAST) begin
        source_nxt = {source_r[39:0], b};
      end else if (pos == ffdc_pkg::POS_SRC_SSID) begin
        src_ssid_nxt = b;
      end else if (pos == ffdc_pkg::POS_CONTROL) begin
        control_nxt = b;
      end else begin
        pid_nxt = b;
      end
    end else if (pos < ffdc_pkg::POS_HSUM) begin
      info_sum_nxt = info_sum_r + b;
      // supervisory frames carry no info
      if (!control_r[0]) begin
        res_valid                = 1'b1;
        res_item.result_kind     = ffdc_pkg::KIND_INFO;
        res_item.info_byte       = b;
        res_item.info_index      = pos - ffdc_pkg::POS_INFO_FIRST;
      end
    end else if (pos == ffdc_pkg::POS_HSUM) begin
      hsum_bad_nxt = ((8'd0 - header_sum_r) != b);
    end else if (pos == ffdc_pkg::POS_ISUM) begin
      isum_bad_nxt = ((8'd0 - info_sum_r) != b);
    end else begin
      res_valid               = 1'b1;
      res_item.result_kind    = ffdc_pkg::KIND_STATUS;
      res_item.frame_status   = st;
      res_item.sender_address = source_r;
      if (st == ffdc_pkg::ST_INFO || st == ffdc_pkg::ST_SUPERVISOR ||
          st == ffdc_pkg::ST_PID || st == ffdc_pkg::ST_INFO_SUM) begin
        res_item.frame_is_response = sc;
        res_item.receive_sequence  = control_r[7:5] & ffdc_pkg::SEQ_MASK;
        res_item.send_sequence     = sup ? 3'd0 : (control_r[3:1] & ffdc_pkg::SEQ_MASK);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      header_sum_r <= '0;
      info_sum_r   <= '0;
      start_ok_r   <= 1'b0;
      addr_miss_r  <= 1'b0;
      dest_ssid_r  <= '0;
      source_r     <= '0;
      src_ssid_r   <= '0;
      control_r    <= '0;
      pid_r        <= '0;
      hsum_bad_r   <= 1'b0;
      isum_bad_r   <= 1'b0;
    end else if (step) begin
      pos_r        <= pos_nxt;
      header_sum_r <= header_sum_nxt;
      info_sum_r   <= info_sum_nxt;
      start_ok_r   <= start_ok_nxt;
      addr_miss_r  <= addr_miss_nxt;
      dest_ssid_r  <= dest_ssid_nxt;
      source_r     <= source_nxt;
      src_ssid_r   <= src_ssid_nxt;
      control_r    <= control_nxt;
      pid_r        <= pid_nxt;
      hsum_bad_r   <= hsum_bad_nxt;
      isum_bad_r   <= isum_bad_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ffdc_out_reg.sv -----
// result register of the deframer with valid/ready output handshake
// depends on ffdc_pkg; loaded from ffdc_frame_track
`default_nettype none

module ffdc_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire ffdc_pkg::out_item_t load_item,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ffdc_pkg::out_item_t    out_item
);

  logic               valid_r, valid_nxt;
  ffdc_pkg::out_item_t item_r;

  // slot can take a new result when empty or being drained this cycle
  assign free      = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_fixed_frame_deframer_checker.sv -----
// self-checking testbench for the fixed 64-byte frame deframer and checker
// needs ffdc_pkg and fixed_frame_deframer_checker; predicts every info and status item
// from its own frame tracker and compares each one as it leaves the block

module tb_fixed_frame_deframer_checker;
  timeunit 1ns;
  timeprecision 1ps;

  // quiet cycles before the run is declared hung
  localparam int unsigned HANG_LIMIT = 5000;
  // cap on a single sender gap so the hang counter never trips on a legal gap
  localparam int unsigned MAX_GAP = 300;
  // bytes of random traffic per random phase
  localparam int unsigned PHASE_BYTES = 48;
  // cycles to let in-flight bytes drain once nothing more is expected
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 10;

  // ways a composed frame can be broken, one bit each in a fault mask
  typedef enum int unsigned {
    FLT_START_FLAG,
    FLT_END_FLAG,
    FLT_HDR_SUM,
    FLT_ADDRESS,
    FLT_DEST_SSID,
    FLT_SRC_SSID,
    FLT_PAIRING,
    FLT_PID,
    FLT_INFO_SUM
  } fault_kind_t;
  localparam int unsigned FAULT_KINDS = 9;
  typedef bit [FAULT_KINDS-1:0] fault_mask_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ffdc_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ffdc_pkg::out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [47:0]         cfg_data = '0;

  // idling knobs, percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // frame tracker state, mirrors what the block must hold
  logic [47:0] own_station = ffdc_pkg::STATION_RESET;
  logic [5:0]  frame_pos = '0;
  logic [7:0]  hdr_sum_acc, info_sum_acc;
  logic        start_flag_seen, dest_addr_differs;
  logic [7:0]  dest_ssid, src_ssid, ctrl_byte, pid_byte;
  logic [47:0] src_addr;
  logic        hdr_sum_wrong, info_sum_wrong;

  ffdc_pkg::out_item_t predicted_results[$];

  // frame being composed for transmission
  logic [7:0]  frame_img[ffdc_pkg::FRAME_BYTES];

  // bookkeeping
  int unsigned failures = 0;
  int unsigned quiet_cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_composed = 0;
  int unsigned info_checked = 0;
  int unsigned status_checked = 0;
  int unsigned station_writes = 0;
  bit [15:0]   statuses_seen = '0;

  fixed_frame_deframer_checker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // receiver backpressure, redrawn every cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // frame tracker: consumes one accepted byte, queues the item it should cause
  // ---------------------------------------------------------------------------

  function automatic void restart_frame_state();
    hdr_sum_acc = '0;
    info_sum_acc = '0;
    start_flag_seen = 1'b0;
    dest_addr_differs = 1'b0;
    dest_ssid = '0;
    src_addr = '0;
    src_ssid = '0;
    ctrl_byte = '0;
    pid_byte = '0;
    hdr_sum_wrong = 1'b0;
    info_sum_wrong = 1'b0;
  endfunction

  function automatic void track_frame_byte(input ffdc_pkg::in_item_t it);
    logic [5:0] p;
    logic [7:0] b;
    logic [3:0] st;
    logic       dest_c, src_c, is_sup;
    ffdc_pkg::out_item_t r;
    b = it.data_byte;
    // a frame start forces byte 0, otherwise the position simply counts on
    p = it.frame_start ? ffdc_pkg::POS_FIRST_FLAG : frame_pos;
    frame_pos = p + 6'd1;
    r = '0;

    if (p == ffdc_pkg::POS_FIRST_FLAG) begin
      restart_frame_state();
      start_flag_seen = (b == ffdc_pkg::FLAG_BYTE);
    end else if (p <= ffdc_pkg::POS_PID) begin
      hdr_sum_acc = hdr_sum_acc + b;
      if (p <= ffdc_pkg::POS_DEST_LAST) begin
        // destination bytes must match our own station, first byte on top
        if (own_station[8*(6-int'(p)) +: 8] != b) dest_addr_differs = 1'b1;
      end else if (p == ffdc_pkg::POS_DEST_SSID) begin
        dest_ssid = b;
      end else if (p <= ffdc_pkg::POS_SRC_LAST) begin
        src_addr = {src_addr[39:0], b};
      end else if (p == ffdc_pkg::POS_SRC_SSID) begin
        src_ssid = b;
      end else if (p == ffdc_pkg::POS_CONTROL) begin
        ctrl_byte = b;
      end else begin
        pid_byte = b;
      end
    end else if (p < ffdc_pkg::POS_HSUM) begin
      info_sum_acc = info_sum_acc + b;
      // supervisory frames swallow their info field
      if (!ctrl_byte[0]) begin
        r.result_kind = ffdc_pkg::KIND_INFO;
        r.info_byte = b;
        r.info_index = p - ffdc_pkg::POS_INFO_FIRST;
        predicted_results.push_back(r);
      end
    end else if (p == ffdc_pkg::POS_HSUM) begin
      hdr_sum_wrong = ((8'd0 - hdr_sum_acc) != b);
    end else if (p == ffdc_pkg::POS_ISUM) begin
      info_sum_wrong = ((8'd0 - info_sum_acc) != b);
    end else begin
      // closing flag position: one status item, first failing check wins
      dest_c = dest_ssid[7];
      src_c = src_ssid[7];
      is_sup = ctrl_byte[0];
      if (!start_flag_seen) st = ffdc_pkg::ST_START_FLAG;
      else if (b != ffdc_pkg::FLAG_BYTE) st = ffdc_pkg::ST_END_FLAG;
      else if (hdr_sum_wrong) st = ffdc_pkg::ST_HDR_SUM;
      else if (dest_addr_differs) st = ffdc_pkg::ST_ADDRESS;
      else if ((dest_ssid & ffdc_pkg::SSID_RES) != ffdc_pkg::SSID_RES || dest_ssid[0])
        st = ffdc_pkg::ST_DEST_SSID;
      else if ((src_ssid & ffdc_pkg::SSID_RES) != ffdc_pkg::SSID_RES || !src_ssid[0])
        st = ffdc_pkg::ST_SRC_SSID;
      else if (dest_c == src_c) st = ffdc_pkg::ST_PAIRING;
      else if (is_sup) st = ffdc_pkg::ST_SUPERVISOR;
      else if (pid_byte != ffdc_pkg::PID_NONE) st = ffdc_pkg::ST_PID;
      else if (info_sum_wrong) st = ffdc_pkg::ST_INFO_SUM;
      else st = ffdc_pkg::ST_INFO;

      r.result_kind = ffdc_pkg::KIND_STATUS;
      r.frame_status = st;
      r.sender_address = src_addr;
      // role and sequence numbers only mean something once the header passed
      if (st == ffdc_pkg::ST_INFO || st == ffdc_pkg::ST_SUPERVISOR ||
          st == ffdc_pkg::ST_PID || st == ffdc_pkg::ST_INFO_SUM) begin
        r.frame_is_response = src_c;
        r.receive_sequence = ctrl_byte[7:5] & ffdc_pkg::SEQ_MASK;
        r.send_sequence = is_sup ? 3'd0 : (ctrl_byte[3:1] & ffdc_pkg::SEQ_MASK);
      end
      predicted_results.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic string describe(input ffdc_pkg::out_item_t r);
    return $sformatf("kind=%0d byte=%h idx=%0d st=%0d src=%h rsp=%0d ns=%0d nr=%0d",
                     r.result_kind, r.info_byte, r.info_index, r.frame_status,
                     r.sender_address, r.frame_is_response, r.send_sequence,
                     r.receive_sequence);
  endfunction

  task automatic check_result(input ffdc_pkg::out_item_t got);
    ffdc_pkg::out_item_t want;
    bit                  bad;
    if (predicted_results.size() == 0) begin
      failures++;
      if (failures <= MAX_REPORTS)
        $display("%0t: item with nothing expected: %s", $realtime, describe(got));
    end else begin
      want = predicted_results.pop_front();
      bad = (got.result_kind !== want.result_kind) ||
            (got.info_byte !== want.info_byte) ||
            (got.info_index !== want.info_index) ||
            (got.frame_status !== want.frame_status) ||
            (got.sender_address !== want.sender_address) ||
            (got.frame_is_response !== want.frame_is_response) ||
            (got.send_sequence !== want.send_sequence) ||
            (got.receive_sequence !== want.receive_sequence);
      if (want.result_kind == ffdc_pkg::KIND_STATUS) begin
        status_checked++;
        statuses_seen[want.frame_status] = 1'b1;
      end else begin
        info_checked++;
      end
      if (bad) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("%0t: mismatch, expected %s", $realtime, describe(want));
          $display("%0t:           actual   %s", $realtime, describe(got));
        end
      end
    end
  endtask

  // output side check plus the hang counter
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_item);
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // hang guard
  initial begin
    while (quiet_cycles < HANG_LIMIT) @(posedge clk);
    $display("%0t: no handshake for %0d cycles", $realtime, HANG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one byte item; an idle gap is drawn first, then valid is held until taken
  task automatic send_byte(input logic [7:0] b, input logic start);
    int unsigned        gap;
    ffdc_pkg::in_item_t it;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    it.data_byte = b;
    it.frame_start = start;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    track_frame_byte(it);
    bytes_sent++;
  endtask

  // station address write, only once the block has gone quiet
  task automatic write_station(input logic [47:0] addr);
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    // bytes that cause no item may still sit in the pipeline
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= addr;
    do @(posedge clk); while (!cfg_ready);
    own_station = addr;
    station_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // ---------------------------------------------------------------------------
  // frame composition
  // ---------------------------------------------------------------------------

  // checksum bytes: two's complement of the header and info byte sums
  function automatic void seal_sums();
    logic [7:0] hs, is;
    hs = '0;
    is = '0;
    for (int i = 1; i <= 16; i++) hs = hs + frame_img[i];
    for (int i = 17; i < 17 + ffdc_pkg::INFO_BYTES; i++) is = is + frame_img[i];
    frame_img[ffdc_pkg::POS_HSUM] = 8'd0 - hs;
    frame_img[ffdc_pkg::POS_ISUM] = 8'd0 - is;
  endfunction

  function automatic logic [7:0] not_flag();
    logic [7:0] v;
    v = 8'($urandom);
    if (v == ffdc_pkg::FLAG_BYTE) v = v ^ 8'h01;
    return v;
  endfunction

  // well-formed frame to dest, then the requested faults applied on top
  function automatic void compose_frame(input logic [47:0] dest, input bit sup,
                                        input bit resp, input fault_mask_t faults);
    logic [7:0] pid;
    frames_composed++;
    frame_img[ffdc_pkg::POS_FIRST_FLAG] = ffdc_pkg::FLAG_BYTE;
    for (int i = 1; i <= 6; i++) frame_img[i] = dest[8*(6-i) +: 8];
    // command: destination C bit set, response: source C bit set
    frame_img[ffdc_pkg::POS_DEST_SSID] =
      {~resp, ffdc_pkg::SSID_RES[6:5], 4'($urandom), 1'b0};
    for (int i = 8; i <= 13; i++) frame_img[i] = 8'($urandom);
    frame_img[ffdc_pkg::POS_SRC_SSID] =
      {resp, ffdc_pkg::SSID_RES[6:5], 4'($urandom), 1'b1};
    frame_img[ffdc_pkg::POS_CONTROL] = {7'($urandom), sup};
    frame_img[ffdc_pkg::POS_PID] = ffdc_pkg::PID_NONE;
    for (int i = 17; i < 17 + ffdc_pkg::INFO_BYTES; i++) frame_img[i] = 8'($urandom);
    frame_img[ffdc_pkg::POS_LAST] = ffdc_pkg::FLAG_BYTE;

    if (faults[FLT_ADDRESS]) begin
      int unsigned k;
      k = $urandom_range(1, 6);
      frame_img[k] = frame_img[k] ^ (8'd1 << $urandom_range(7));
    end
    if (faults[FLT_DEST_SSID]) begin
      if ($urandom_range(1)) frame_img[ffdc_pkg::POS_DEST_SSID][0] = 1'b1;
      else frame_img[ffdc_pkg::POS_DEST_SSID][5 + $urandom_range(1)] = 1'b0;
    end
    if (faults[FLT_SRC_SSID]) begin
      if ($urandom_range(1)) frame_img[ffdc_pkg::POS_SRC_SSID][0] = 1'b0;
      else frame_img[ffdc_pkg::POS_SRC_SSID][5 + $urandom_range(1)] = 1'b0;
    end
    if (faults[FLT_PAIRING]) begin
      // both C bits equal, either both set or both clear
      frame_img[ffdc_pkg::POS_DEST_SSID][7] = frame_img[ffdc_pkg::POS_SRC_SSID][7];
    end
    if (faults[FLT_PID]) begin
      pid = 8'($urandom);
      if (pid == ffdc_pkg::PID_NONE) pid = pid ^ 8'h01;
      frame_img[ffdc_pkg::POS_PID] = pid;
    end
    seal_sums();
    if (faults[FLT_HDR_SUM])
      frame_img[ffdc_pkg::POS_HSUM] = frame_img[ffdc_pkg::POS_HSUM] ^ 8'($urandom_range(1, 255));
    if (faults[FLT_INFO_SUM])
      frame_img[ffdc_pkg::POS_ISUM] = frame_img[ffdc_pkg::POS_ISUM] ^ 8'($urandom_range(1, 255));
    if (faults[FLT_START_FLAG]) frame_img[ffdc_pkg::POS_FIRST_FLAG] = not_flag();
    if (faults[FLT_END_FLAG]) frame_img[ffdc_pkg::POS_LAST] = not_flag();
  endfunction

  // sends the first count bytes of the composed frame
  task automatic send_frame(input int unsigned count, input bit with_start);
    for (int unsigned i = 0; i < count; i++)
      send_byte(frame_img[i], with_start && (i == 0));
  endtask

  // frame start is mandatory unless the position already sits at byte 0
  function automatic bit pick_start();
    return (frame_pos != ffdc_pkg::POS_FIRST_FLAG) || ($urandom_range(99) < 70);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // first frames after reset: reset station address, no frame start needed
  task automatic test_reset_frames();
    compose_frame(own_station, 1'b0, 1'b0, '0);
    // payload extremes at both ends of the info field
    frame_img[ffdc_pkg::POS_INFO_FIRST] = 8'h00;
    frame_img[ffdc_pkg::POS_HSUM - 1] = 8'hff;
    seal_sums();
    send_frame(ffdc_pkg::FRAME_BYTES, 1'b0);
    // supervisory response: info dropped, N(S) forced to zero
    compose_frame(own_station, 1'b1, 1'b1, '0);
    send_frame(ffdc_pkg::FRAME_BYTES, 1'b1);
  endtask

  // every check failing on its own, then stacked to exercise priority
  task automatic test_status_priority();
    fault_mask_t f;
    for (int unsigned k = 0; k < FAULT_KINDS; k++) begin
      f = '0;
      f[k] = 1'b1;
      compose_frame(own_station, 1'b0, k[0], f);
      send_frame(ffdc_pkg::FRAME_BYTES, 1'b1);
    end
    // all checks failing at once: start flag must win
    compose_frame(own_station, 1'b0, 1'b1, '1);
    send_frame(ffdc_pkg::FRAME_BYTES, 1'b1);
    // supervisory outranks a bad pid and a bad info sum
    f = '0;
    f[FLT_PID] = 1'b1;
    f[FLT_INFO_SUM] = 1'b1;
    compose_frame(own_station, 1'b1, 1'b0, f);
    send_frame(ffdc_pkg::FRAME_BYTES, 1'b1);
    // bad pid outranks a bad info sum on an info frame
    compose_frame(own_station, 1'b0, 1'b0, f);
    send_frame(ffdc_pkg::FRAME_BYTES, 1'b1);
  endtask

  // frame start in the middle of a frame, then a frame found by wrapping alone
  task automatic test_frame_restart();
    compose_frame(own_station, 1'b0, 1'b0, '0);
    send_frame(30, 1'b1);
    compose_frame(own_station, 1'b0, 1'b1, '0);
    send_frame(ffdc_pkg::FRAME_BYTES, 1'b1);
    compose_frame(own_station, 1'b0, 1'b0, '0);
    send_frame(ffdc_pkg::FRAME_BYTES, 1'b0);
  endtask

  // mostly well-formed frames with random content, some broken ones and noise
  task automatic test_random_traffic(input int unsigned byte_budget);
    int unsigned first_byte, pick, n;
    fault_mask_t f;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < byte_budget) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        compose_frame(own_station, ($urandom_range(3) == 0), $urandom_range(1), '0);
        send_frame(ffdc_pkg::FRAME_BYTES, pick_start());
      end else if (pick < 85) begin
        f = '0;
        f[$urandom_range(FAULT_KINDS - 1)] = 1'b1;
        if ($urandom_range(2) == 0) f[$urandom_range(FAULT_KINDS - 1)] = 1'b1;
        compose_frame(own_station, ($urandom_range(3) == 0), $urandom_range(1), f);
        send_frame(ffdc_pkg::FRAME_BYTES, pick_start());
      end else if (pick < 93) begin
        // frame cut short, the next one must restart cleanly
        compose_frame(own_station, $urandom_range(1), $urandom_range(1), '0);
        send_frame($urandom_range(1, ffdc_pkg::FRAME_BYTES - 1), pick_start());
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) send_byte(8'($urandom), ($urandom_range(9) == 0));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    restart_frame_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // no idling: frames right after reset, then restart handling
    set_idling(0, 0);
    test_reset_frames();
    test_frame_restart();

    // sender idle most of the time, all-zero station address
    set_idling(85, 0);
    write_station(48'h0);
    test_random_traffic(PHASE_BYTES);

    // receiver stalling most of the time, all-ones station address
    set_idling(0, 85);
    write_station(48'hFFFF_FFFF_FFFF);
    test_status_priority();

    // light idling on both sides, random station address
    set_idling(7, 7);
    write_station({16'($urandom), 32'($urandom)});
    test_random_traffic(PHASE_BYTES);

    // drain
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    failures += predicted_results.size();

    $display("covered %0d bytes in %0d frames over %0d station addresses",
             bytes_sent, frames_composed, station_writes + 1);
    $display("checked %0d info and %0d status items, %0d of 11 status codes hit",
             info_checked, status_checked, $countones(statuses_seen));
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures", failures);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ffdc_pkg.sv
hdl/ffdc_frame_track.sv
hdl/ffdc_out_reg.sv
hdl/fixed_frame_deframer_checker.sv
sim/tb_fixed_frame_deframer_checker.sv
